// File: sv/mwo_pkg.sv
// mwo_pkg: shared types, codes and the sine table generator for the oscillator.
// No dependencies; used by every module of the oscillator.
`default_nettype none

package mwo_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int P_BITS      = 32;   // phase word seen by the waveform math
	localparam int QUEUE_DEPTH = 2;
	localparam int ROM_W       = 17;   // Q16 magnitude, 0..65536

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SERIES_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2,
		WAVE_TRI    = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVE  = 2'd0,
		REG_INC   = 2'd1,
		REG_AMP   = 2'd2,
		REG_TOTAL = 2'd3
	} reg_idx_t;

	// one queued sample request: top 32 phase bits plus end-of-run flag
	typedef struct packed {
		logic [P_BITS-1:0] p;
		logic              last;
	} item_t;

	// Taylor series sine, Q16; evaluated at elaboration only
	function automatic logic [ROM_W-1:0] sine_q16(input int unsigned k, input int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] r;
		longint      s;
		x  = (64'(k) * HALF_PI_Q30) >> tb;
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			t = ((t * x2) >> 30) / SERIES_DIV[n-1];
			if ((n % 2) == 1) begin
				s = s - longint'(t);
			end else begin
				s = s + longint'(t);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		r = (64'(s) + 64'd8192) >> 14;
		return (r > 64'd65536) ? ROM_W'(65536) : r[ROM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/multi_waveform_oscillator.sv
// multi_waveform_oscillator: DDS sine/square/sawtooth/triangle sample source.
// Depends on mwo_pkg, mwo_front, mwo_fifo, mwo_back.
`default_nettype none

// Channel   Signals                          Transfer when
// -------   ------------------------------   ------------------------
// input     in_valid, in_ready, restart      in_valid && in_ready
// output    out_valid, out_ready, sample,    out_valid && out_ready
//           last
// config    cfg_we, cfg_index, cfg_data      cfg_we (no wait)
//
// One sample per clock sustained while out_ready holds. From an input
// transfer to out_valid: the queue is written at the transfer edge, then
// the ROM read, multiply and output registers follow in that order.
// The front accumulates phase in the transfer cycle; the back is a 3-stage
// pipe around the sine ROM and a single 16x33 multiplier.
// Reset clears phase, sample index, queue, pipe valids and config registers.
// An output stall freezes the back pipe; the front keeps taking transfers
// until the two-entry queue fills, then drops in_ready.

module multi_waveform_oscillator #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] sample,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	mwo_pkg::wave_t wave_q;
	logic [31:0]    phase_inc_q;
	logic [14:0]    amplitude_q;
	logic [31:0]    sample_total_q;

	logic           push;
	mwo_pkg::item_t push_item;
	logic           q_full;
	logic           q_valid;
	logic           back_ready;
	mwo_pkg::item_t q_item;

	// config registers; values are masked to register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q         <= mwo_pkg::WAVE_SINE;
			phase_inc_q    <= '0;
			amplitude_q    <= '0;
			sample_total_q <= '0;
		end else if (cfg_we) begin
			unique case (mwo_pkg::reg_idx_t'(cfg_index))
				mwo_pkg::REG_WAVE:  wave_q         <= mwo_pkg::wave_t'(cfg_data[1:0]);
				mwo_pkg::REG_INC:   phase_inc_q    <= cfg_data;
				mwo_pkg::REG_AMP:   amplitude_q    <= cfg_data[14:0];
				mwo_pkg::REG_TOTAL: sample_total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mwo_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.phase_inc    (phase_inc_q),
		.sample_total (sample_total_q),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	mwo_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_ready (back_ready),
		.pop_item  (q_item)
	);

	mwo_back #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wave      (wave_q),
		.amplitude (amplitude_q),
		.q_valid   (q_valid),
		.q_ready   (back_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.last      (last)
	);

	// an accepted transfer always leaves something queued next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> q_valid)
		else $error("input transfer did not reach the queue");

	// backpressure on the input only when the queue really holds items
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("in_ready low with an empty queue");

	// a queued item with the back pipe free must be taken
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !out_valid) |-> back_ready)
		else $error("back pipe stalled with an empty output register");

endmodule

`default_nettype wire

// File: sv/mwo_front.sv
// mwo_front: phase accumulator and sample counter; turns each input transfer
// into a queued request. Depends on mwo_pkg.
`default_nettype none

module mwo_front #(
	parameter int PHASE_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              restart,
	input  wire logic [31:0]       phase_inc,
	input  wire logic [31:0]       sample_total,
	output logic                   push,
	output mwo_pkg::item_t         push_item,
	input  wire logic              q_full
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [31:0]           index_q;
	logic [PHASE_BITS-1:0] phase_cur;
	logic [31:0]           index_cur;
	logic [PHASE_BITS-1:0] inc_al;
	logic [31:0]           p_cur;

	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;
	assign phase_cur = restart ? '0 : phase_q;
	assign index_cur = restart ? '0 : index_q;

	// align to a 32-bit cycle fraction
	if (PHASE_BITS == 32) begin : g_eq
		assign p_cur  = phase_cur;
		assign inc_al = phase_inc;
	end else if (PHASE_BITS > 32) begin : g_wide
		assign p_cur  = phase_cur[PHASE_BITS-1 -: 32];
		assign inc_al = {phase_inc, {(PHASE_BITS-32){1'b0}}};
	end else begin : g_narrow
		assign p_cur  = {phase_cur, {(32-PHASE_BITS){1'b0}}};
		assign inc_al = phase_inc[31 -: PHASE_BITS];
	end

	assign push_item.p    = p_cur;
	assign push_item.last = (sample_total != '0) && (index_cur == (sample_total - 32'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			index_q <= '0;
		end else if (push) begin
			phase_q <= phase_cur + inc_al;
			index_q <= index_cur + 32'd1;
		end
	end

endmodule

`default_nettype wire

// File: sv/mwo_fifo.sv
// mwo_fifo: short request queue between front and back.
// Depends on mwo_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module mwo_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mwo_pkg::item_t push_item,
	output logic                full,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output mwo_pkg::item_t      pop_item
);

	localparam int DEPTH = mwo_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mwo_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/mwo_back.sv
// mwo_back: waveform datapath - sine ROM, one multiplier, rounding, output register.
// Depends on mwo_pkg (sine_q16, wave_t, item_t).
`default_nettype none

module mwo_back #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mwo_pkg::wave_t             wave,
	input  wire logic [14:0]                amplitude,
	input  wire logic                       q_valid,
	output logic                            q_ready,
	input  wire mwo_pkg::item_t             q_item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample,
	output logic                            last
);

	localparam int TB    = SINE_TABLE_BITS;
	localparam int TAB_N = (1 << TB) + 1;
	localparam int SW    = mwo_pkg::SAMPLE_BITS;
	localparam int RW    = mwo_pkg::ROM_W;

	logic [RW-1:0] rom [TAB_N];

	for (genvar k = 0; k < TAB_N; k++) begin : g_rom
		assign rom[k] = mwo_pkg::sine_q16(k, TB);
	end

	logic en;

	// stage 1 inputs
	logic [31:0]        p;
	logic [TB-1:0]      tab_i;
	logic [TB:0]        rom_addr;
	logic signed [32:0] d_ext;
	logic signed [32:0] d_abs;
	logic signed [SW-1:0] amp_s;

	// stage 1
	logic                 v_s1;
	logic [RW-1:0]        rom_s1;
	logic signed [32:0]   opd_s1;
	logic                 neg_s1;
	logic signed [SW-1:0] sq_s1;
	logic                 last_s1;

	// stage 2
	logic signed [32:0]   mul_b;
	logic signed [32:0]   mag;
	logic                 v_s2;
	logic signed [48:0]   prod_s2;
	logic signed [SW-1:0] sq_s2;
	logic                 last_s2;

	// stage 3
	logic signed [48:0]   r_sine;
	logic signed [48:0]   r_saw;
	logic signed [48:0]   r_tri;
	logic signed [SW-1:0] res;

	logic                 valid_q;
	logic signed [SW-1:0] sample_q;
	logic                 last_q;

	// whole pipe advances together; the output register frees it
	assign en      = !valid_q || out_ready;
	assign q_ready = en;

	assign p        = q_item.p;
	assign tab_i    = p[29 -: TB];
	assign rom_addr = p[30] ? ({1'b1, {TB{1'b0}}} - {1'b0, tab_i}) : {1'b0, tab_i};
	assign d_ext    = {p[31], p};
	assign d_abs    = p[31] ? -d_ext : d_ext;
	assign amp_s    = {1'b0, amplitude};

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1  <= rom[rom_addr];
			opd_s1  <= (wave == mwo_pkg::WAVE_TRI) ? d_abs : d_ext;
			neg_s1  <= p[31];
			sq_s1   <= ((p != '0) && !p[31]) ? amp_s : -amp_s;
			last_s1 <= q_item.last;
		end
	end

	assign mag   = {{(33-RW){1'b0}}, rom_s1};
	assign mul_b = (wave == mwo_pkg::WAVE_SINE) ? (neg_s1 ? -mag : mag) : opd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= amp_s * mul_b;
			sq_s2   <= sq_s1;
			last_s2 <= last_s1;
		end
	end

	// round to nearest, ties up: add half an LSB, then arithmetic shift
	assign r_sine = (prod_s2 + 49'sd32768) >>> 16;
	assign r_saw  = (prod_s2 + (49'sd1 <<< 30)) >>> 31;
	assign r_tri  = ((prod_s2 + (49'sd1 <<< 29)) >>> 30) - 49'(amp_s);

	always_comb begin
		unique case (wave)
			mwo_pkg::WAVE_SINE:   res = r_sine[SW-1:0];
			mwo_pkg::WAVE_SQUARE: res = sq_s2;
			mwo_pkg::WAVE_SAW:    res = r_saw[SW-1:0];
			mwo_pkg::WAVE_TRI:    res = r_tri[SW-1:0];
			default:              res = sq_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= res;
			last_q   <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= q_valid;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	assign out_valid = valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

endmodule

`default_nettype wire
